FILE: sv/mp2d_pkg.sv
// Shared types and constants for the streaming 2-D max pooling block.
package mp2d_pkg;

   // Widths of the configuration registers and the write port
   localparam int WINDOW_REG_BITS = 4;
   localparam int PLANE_REG_BITS  = 11;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 11;

   // Reset values of the configuration registers
   localparam logic [WINDOW_REG_BITS-1:0] WINDOW_ROWS_RESET = 4'd2;
   localparam logic [WINDOW_REG_BITS-1:0] WINDOW_COLS_RESET = 4'd2;
   localparam logic [PLANE_REG_BITS-1:0]  PLANE_ROWS_RESET  = 11'd32;
   localparam logic [PLANE_REG_BITS-1:0]  PLANE_COLS_RESET  = 11'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_ROWS = 3'd0,
      CSR_WINDOW_COLS = 3'd1,
      CSR_PLANE_ROWS  = 3'd2,
      CSR_PLANE_COLS  = 3'd3
   } csr_index_type;

endpackage

FILE: sv/mp2d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mp2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: sv/max_pooling_2d_stream_core.sv
// Top level of the streaming 2-D max pooling block: counters, line buffer, output register.
// A result reaches rsp_ through the stage 1 register and then the output register.
// Throughput: one sample per cycle while req_stall is low; the line buffer is read in the
//   acceptance cycle, written back by stage 1; a one-entry forward covers back-to-back reuse.
// Reset: clears positions, window counters, running maximum and output valid, and loads the
//   register defaults (2x2 window, 32x32 plane); the line buffer is not cleared.
module max_pooling_2d_stream_core
   import mp2d_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int MAX_WINDOW  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_pooled,
   output logic                          rsp_row_end,
   output logic                          rsp_plane_end,
   // configuration write port
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   // Widths derived from the size limits
   localparam int AW  = $clog2(MAX_COLS);            // column / row position, buffer address
   localparam int DW  = $clog2(MAX_COLS + 1);        // plane size after clamping
   localparam int WW  = $clog2(MAX_WINDOW + 1);      // window size after clamping
   localparam int CIW = $clog2(MAX_WINDOW);          // offset inside a window
   localparam int PEW = (DW > PLANE_REG_BITS) ? DW : PLANE_REG_BITS;
   localparam int WEW = (WW > WINDOW_REG_BITS) ? WW : WINDOW_REG_BITS;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [WINDOW_REG_BITS-1:0] window_rows_ff, window_rows_in;
   logic [WINDOW_REG_BITS-1:0] window_cols_ff, window_cols_in;
   logic [PLANE_REG_BITS-1:0]  plane_rows_ff,  plane_rows_in;
   logic [PLANE_REG_BITS-1:0]  plane_cols_ff,  plane_cols_in;
   logic                       restart;

   always_comb begin
      window_rows_in = window_rows_ff;
      window_cols_in = window_cols_ff;
      plane_rows_in  = plane_rows_ff;
      plane_cols_in  = plane_cols_ff;
      restart        = 1'b0;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_ROWS: begin
               window_rows_in = csr_write_data[WINDOW_REG_BITS-1:0];
               restart        = 1'b1;
            end
            CSR_WINDOW_COLS: begin
               window_cols_in = csr_write_data[WINDOW_REG_BITS-1:0];
               restart        = 1'b1;
            end
            CSR_PLANE_ROWS: begin
               plane_rows_in = csr_write_data[PLANE_REG_BITS-1:0];
               restart       = 1'b1;
            end
            CSR_PLANE_COLS: begin
               plane_cols_in = csr_write_data[PLANE_REG_BITS-1:0];
               restart       = 1'b1;
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_rows_ff <= WINDOW_ROWS_RESET;
         window_cols_ff <= WINDOW_COLS_RESET;
         plane_rows_ff  <= PLANE_ROWS_RESET;
         plane_cols_ff  <= PLANE_COLS_RESET;
      end else begin
         window_rows_ff <= window_rows_in;
         window_cols_ff <= window_cols_in;
         plane_rows_ff  <= plane_rows_in;
         plane_cols_ff  <= plane_cols_in;
      end
   end

   // Clamp sizes: zero counts as one, anything above the limit saturates
   logic [WW-1:0]  wr, wc;
   logic [DW-1:0]  pr, pc;
   logic [WEW-1:0] wr_ext, wc_ext;
   logic [PEW-1:0] pr_ext, pc_ext;

   always_comb begin
      wr_ext = WEW'(window_rows_ff);
      wc_ext = WEW'(window_cols_ff);
      pr_ext = PEW'(plane_rows_ff);
      pc_ext = PEW'(plane_cols_ff);

      if (wr_ext == '0)                    wr = WW'(1);
      else if (wr_ext > WEW'(MAX_WINDOW))  wr = WW'(MAX_WINDOW);
      else                                 wr = wr_ext[WW-1:0];

      if (wc_ext == '0)                    wc = WW'(1);
      else if (wc_ext > WEW'(MAX_WINDOW))  wc = WW'(MAX_WINDOW);
      else                                 wc = wc_ext[WW-1:0];

      if (pr_ext == '0)                    pr = DW'(1);
      else if (pr_ext > PEW'(MAX_COLS))    pr = DW'(MAX_COLS);
      else                                 pr = pr_ext[DW-1:0];

      if (pc_ext == '0)                    pc = DW'(1);
      else if (pc_ext > PEW'(MAX_COLS))    pc = DW'(MAX_COLS);
      else                                 pc = pc_ext[DW-1:0];
   end

   // ------------------------------------------------------------------
   // Stage 0: position counters and running horizontal maximum
   // ------------------------------------------------------------------
   logic [AW-1:0]  row_pos_ff, row_pos_in;
   logic [AW-1:0]  col_pos_ff, col_pos_in;
   logic [CIW-1:0] row_win_ff, row_win_in;
   logic [CIW-1:0] col_win_ff, col_win_in;
   logic [AW-1:0]  out_col_ff, out_col_in;
   logic           row_ok_ff,  row_ok_in;
   logic signed [SAMPLE_BITS-1:0] run_max_ff, run_max_in;

   logic accept;
   logic s1_move;
   logic row_ok, col_ok, in_region, complete;
   logic last_row_of_win, row_end, plane_end;
   logic [DW:0] row_pos_x, col_pos_x, pr_x, pc_x, wr_x, wc_x;
   logic [DW-1:0] col_next, row_next;
   logic [WW-1:0] col_win_next, row_win_next;

   assign accept = req_valid && !req_stall;

   always_comb begin
      row_pos_x = (DW + 1)'(row_pos_ff);
      col_pos_x = (DW + 1)'(col_pos_ff);
      pr_x      = (DW + 1)'(pr);
      pc_x      = (DW + 1)'(pc);
      wr_x      = (DW + 1)'(wr);
      wc_x      = (DW + 1)'(wc);

      // A row window is whole when all its rows fit; decide at its first row and hold
      row_ok = (row_win_ff == '0) ? (row_pos_x + wr_x <= pr_x) : row_ok_ff;
      // A column window is whole when all its columns fit; decided at its first column
      col_ok = (col_win_ff != '0) || (col_pos_x + wc_x <= pc_x);
      in_region = row_ok && col_ok;

      col_win_next    = WW'(col_win_ff) + WW'(1);
      row_win_next    = WW'(row_win_ff) + WW'(1);
      complete        = (col_win_next >= wc);
      last_row_of_win = (row_win_next >= wr);
      // No further whole window to the right / below
      row_end   = (col_pos_x + (DW + 1)'(1) + wc_x > pc_x);
      plane_end = row_end && (row_pos_x + (DW + 1)'(1) + wr_x > pr_x);

      col_next = DW'(col_pos_ff) + DW'(1);
      row_next = DW'(row_pos_ff) + DW'(1);
   end

   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      row_win_in = row_win_ff;
      col_win_in = col_win_ff;
      out_col_in = out_col_ff;
      row_ok_in  = row_ok_ff;
      run_max_in = run_max_ff;

      if (restart) begin
         row_pos_in = '0;
         col_pos_in = '0;
         row_win_in = '0;
         col_win_in = '0;
         out_col_in = '0;
      end else if (accept) begin
         row_ok_in = row_ok;
         if (in_region) begin
            if ((col_win_ff == '0) || (req_sample > run_max_ff)) begin
               run_max_in = req_sample;
            end
            if (complete) begin
               out_col_in = out_col_ff + AW'(1);
               col_win_in = '0;
            end else begin
               col_win_in = col_win_next[CIW-1:0];
            end
         end
         col_pos_in = col_next[AW-1:0];
         // End of input row: rewind columns, advance rows, wrap to row 0 at the end of the plane
         if (col_next >= pc) begin
            col_pos_in = '0;
            col_win_in = '0;
            out_col_in = '0;
            row_win_in = last_row_of_win ? '0 : row_win_next[CIW-1:0];
            row_pos_in = row_next[AW-1:0];
            if (row_next >= pr) begin
               row_pos_in = '0;
               row_win_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         row_win_ff <= '0;
         col_win_ff <= '0;
         out_col_ff <= '0;
         row_ok_ff  <= 1'b0;
         run_max_ff <= '0;
      end else begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
         row_win_ff <= row_win_in;
         col_win_ff <= col_win_in;
         out_col_ff <= out_col_in;
         row_ok_ff  <= row_ok_in;
         run_max_ff <= run_max_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: fold the horizontal maximum into the line buffer entry
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [AW-1:0]                 addr;
      logic signed [SAMPLE_BITS-1:0] horz;
      logic                          first_row;
      logic                          emit;
      logic                          row_end;
      logic                          plane_end;
   } s1_type;

   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;

   logic          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_addr_ff,  fwd_addr_in;
   logic signed [SAMPLE_BITS-1:0] fwd_data_ff, fwd_data_in;

   logic                          ram_rd_en, ram_wr_en;
   logic [SAMPLE_BITS-1:0]        ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] buf_val, combined;
   logic                          out_load;

   logic   out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_pooled_ff, out_pooled_in;
   logic   out_row_end_ff, out_row_end_in;
   logic   out_plane_end_ff, out_plane_end_in;

   // Stage 1 advances unless it holds a result and the output register is stuck
   assign s1_move   = !s1_valid_ff || !s1_ff.emit || !out_valid_ff || !rsp_stall;
   assign req_stall = !s1_move;

   // Read the buffer entry as the sample that closes a horizontal window arrives
   assign ram_rd_en = accept && in_region && complete;

   always_comb begin
      s1_in.addr      = out_col_ff;
      s1_in.horz      = run_max_in;
      s1_in.first_row = (row_win_ff == '0);
      s1_in.emit      = last_row_of_win;
      s1_in.row_end   = row_end;
      s1_in.plane_end = plane_end;
      s1_valid_in     = s1_move ? ram_rd_en : s1_valid_ff;
   end

   // Forward the write made on the edge that issued this read
   always_comb begin
      buf_val = (fwd_valid_ff && (fwd_addr_ff == s1_ff.addr)) ? fwd_data_ff
                                                              : $signed(ram_rd_data);
      combined = (!s1_ff.first_row && (buf_val > s1_ff.horz)) ? buf_val : s1_ff.horz;
   end

   assign ram_wr_en = s1_move && s1_valid_ff && !s1_ff.emit;
   assign out_load  = s1_move && s1_valid_ff && s1_ff.emit;

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (s1_move) begin
         fwd_valid_in = ram_wr_en;
         fwd_addr_in  = s1_ff.addr;
         fwd_data_in  = combined;
      end
   end

   mp2d_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_COLS)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.addr),
      .wr_data (combined),
      .rd_en   (ram_rd_en),
      .rd_addr (out_col_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_ff <= s1_in;
      end
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ------------------------------------------------------------------
   // Output register: load a finished window, hold while stalled
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in     = out_load || (out_valid_ff && rsp_stall);
      out_pooled_in    = out_pooled_ff;
      out_row_end_in   = out_row_end_ff;
      out_plane_end_in = out_plane_end_ff;
      if (out_load) begin
         out_pooled_in    = combined;
         out_row_end_in   = s1_ff.row_end;
         out_plane_end_in = s1_ff.plane_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pooled_ff    <= out_pooled_in;
      out_row_end_ff   <= out_row_end_in;
      out_plane_end_ff <= out_plane_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pooled    = out_pooled_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_plane_end = out_plane_end_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Input is held back only by a result stuck in the output register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // The last window of a plane also closes its output row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_plane_end) |-> rsp_row_end)
      else $error("plane end without row end");

   // A new result appears only after stage 1 handed one over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(out_load))
      else $error("result valid without a stage 1 load");

   // A buffer write and a result load never come from the same stage 1 item
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && out_load))
      else $error("stage 1 both writes back and emits");

endmodule
